@@ rtl/core/pa_pkg.sv @@
// Shared types and constants for the polygon area and bounding box block.
package pa_pkg;

  localparam int COORD_BITS  = 16;
  localparam int MAX_CORNERS = 256;
  localparam int COUNT_BITS  = $clog2(MAX_CORNERS + 1);
  localparam int TERM_BITS   = 2 * COORD_BITS + 1;
  localparam int CROSS_BITS  = 42;
  localparam int AREA_BITS   = CROSS_BITS - 1;
  localparam int REG_COUNT   = 4;
  localparam int ADDR_BITS   = $clog2(REG_COUNT) + 2;
  localparam int DATA_BITS   = 32;

  localparam logic [$clog2(REG_COUNT)-1:0] REG_QUERY_MIN_X = 2'd0;
  localparam logic [$clog2(REG_COUNT)-1:0] REG_QUERY_MAX_X = 2'd1;
  localparam logic [$clog2(REG_COUNT)-1:0] REG_QUERY_MIN_Y = 2'd2;
  localparam logic [$clog2(REG_COUNT)-1:0] REG_QUERY_MAX_Y = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         closes_polygon;
  } vertex_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]         twice_area;
    logic [COUNT_BITS-1:0]        corner_count;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_right;
    logic signed [COORD_BITS-1:0] box_bottom;
    logic signed [COORD_BITS-1:0] box_top;
    logic                         overlaps_query;
    logic                         too_many_corners;
  } result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] max_y;
  } query_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] fx;
    logic signed [COORD_BITS-1:0] fy;
    logic                         last;
    logic                         start;
  } front_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [TERM_BITS-1:0]  edge_term;
    logic signed [TERM_BITS-1:0]  close_term;
    logic                         last;
    logic                         start;
  } cross_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
    logic signed [COORD_BITS-1:0] top;
  } box_t;

  typedef struct packed {
    logic signed [CROSS_BITS-1:0] sum;
    logic [COUNT_BITS-1:0]        count;
    logic                         ovf;
    box_t                         box;
  } closed_t;

endpackage

@@ rtl/core/polygon_area_and_bbox.sv @@
// Top level: query box registers and the four-stage vertex pipeline.
// A closing vertex's result passes through the front, cross, accumulator and result registers in turn.
// Throughput: one vertex per cycle; the shoelace accumulator closes its loop
// through a single register, and a waiting result stalls intake only once the stages behind it are full.
// Reset clears all stage valids, the open-polygon flag and the query box to zero.
module polygon_area_and_bbox (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vertex_valid,
  input  pa_pkg::vertex_t               vertex,
  output logic                          vertex_stall,
  output logic                          result_valid,
  output pa_pkg::result_t               result,
  input  logic                          result_stall,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pa_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [pa_pkg::DATA_BITS-1:0]  pwdata,
  output logic [pa_pkg::DATA_BITS-1:0]  prdata,
  output logic                          pready
);
  import pa_pkg::*;

  query_t                         query;
  logic                           cfg_write;
  logic [$clog2(REG_COUNT)-1:0]   reg_index;
  logic                           front_valid;
  front_t                         front;
  logic                           cross_ready;
  logic                           terms_valid;
  cross_t                         terms;
  logic                           accum_ready;
  logic                           closed_valid;
  closed_t                        closed;
  logic                           result_ready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_QUERY_MIN_X: query.min_x <= pwdata[COORD_BITS-1:0];
        REG_QUERY_MAX_X: query.max_x <= pwdata[COORD_BITS-1:0];
        REG_QUERY_MIN_Y: query.min_y <= pwdata[COORD_BITS-1:0];
        REG_QUERY_MAX_Y: query.max_y <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_QUERY_MIN_X: prdata = DATA_BITS'({1'b0, query.min_x});
      REG_QUERY_MAX_X: prdata = DATA_BITS'({1'b0, query.max_x});
      REG_QUERY_MIN_Y: prdata = DATA_BITS'({1'b0, query.min_y});
      REG_QUERY_MAX_Y: prdata = DATA_BITS'({1'b0, query.max_y});
      default:         prdata = '0;
    endcase
  end

  pa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex       (vertex),
    .vertex_stall (vertex_stall),
    .front_valid  (front_valid),
    .front        (front),
    .down_ready   (cross_ready)
  );

  pa_cross u_cross (
    .clk         (clk),
    .rst         (rst),
    .front_valid (front_valid),
    .front       (front),
    .up_ready    (cross_ready),
    .terms_valid (terms_valid),
    .terms       (terms),
    .down_ready  (accum_ready)
  );

  pa_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .terms_valid  (terms_valid),
    .terms        (terms),
    .up_ready     (accum_ready),
    .closed_valid (closed_valid),
    .closed       (closed),
    .down_ready   (result_ready)
  );

  pa_result u_result (
    .clk          (clk),
    .rst          (rst),
    .closed_valid (closed_valid),
    .closed       (closed),
    .query        (query),
    .up_ready     (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

@@ rtl/core/pa_front.sv @@
// Input register with first and previous vertex tracking.
module pa_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            vertex_valid,
  input  pa_pkg::vertex_t vertex,
  output logic            vertex_stall,
  output logic            front_valid,
  output pa_pkg::front_t  front,
  input  logic            down_ready
);
  import pa_pkg::*;

  logic                         ready;
  logic                         take;
  logic                         open;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;

  assign ready        = !front_valid || down_ready;
  assign take         = vertex_valid && ready;
  assign vertex_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
      open        <= 1'b0;
    end else begin
      if (ready) begin
        front_valid <= vertex_valid;
      end
      if (take) begin
        open <= !vertex.closes_polygon;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      front.x     <= vertex.vertex_x;
      front.y     <= vertex.vertex_y;
      front.px    <= prev_x;
      front.py    <= prev_y;
      front.fx    <= open ? first_x : vertex.vertex_x;
      front.fy    <= open ? first_y : vertex.vertex_y;
      front.last  <= vertex.closes_polygon;
      front.start <= !open;
      prev_x      <= vertex.vertex_x;
      prev_y      <= vertex.vertex_y;
      if (!open) begin
        first_x <= vertex.vertex_x;
        first_y <= vertex.vertex_y;
      end
    end
  end

endmodule

@@ rtl/core/pa_cross.sv @@
// Cross product stage: edge and closing shoelace terms.
module pa_cross (
  input  logic           clk,
  input  logic           rst,
  input  logic           front_valid,
  input  pa_pkg::front_t front,
  output logic           up_ready,
  output logic           terms_valid,
  output pa_pkg::cross_t terms,
  input  logic           down_ready
);
  import pa_pkg::*;

  logic signed [2*COORD_BITS-1:0] edge_p;
  logic signed [2*COORD_BITS-1:0] edge_q;
  logic signed [2*COORD_BITS-1:0] close_p;
  logic signed [2*COORD_BITS-1:0] close_q;

  assign up_ready = !terms_valid || down_ready;

  always_comb begin
    edge_p  = $signed(front.x) * $signed(front.py);
    edge_q  = $signed(front.y) * $signed(front.px);
    close_p = $signed(front.fx) * $signed(front.y);
    close_q = $signed(front.fy) * $signed(front.x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
    end else if (up_ready) begin
      terms_valid <= front_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && front_valid) begin
      terms.x          <= front.x;
      terms.y          <= front.y;
      terms.edge_term  <= TERM_BITS'(edge_p) - TERM_BITS'(edge_q);
      terms.close_term <= TERM_BITS'(close_p) - TERM_BITS'(close_q);
      terms.last       <= front.last;
      terms.start      <= front.start;
    end
  end

endmodule

@@ rtl/core/pa_accum.sv @@
// Shoelace accumulator, vertex count and running bounding box.
module pa_accum (
  input  logic            clk,
  input  logic            rst,
  input  logic            terms_valid,
  input  pa_pkg::cross_t  terms,
  output logic            up_ready,
  output logic            closed_valid,
  output pa_pkg::closed_t closed,
  input  logic            down_ready
);
  import pa_pkg::*;

  logic signed [CROSS_BITS-1:0] cross_sum;
  logic signed [CROSS_BITS-1:0] cross_sum_next;
  logic signed [CROSS_BITS-1:0] edge_add;
  logic signed [CROSS_BITS-1:0] close_add;
  logic [COUNT_BITS-1:0]        seen_count;
  logic [COUNT_BITS-1:0]        seen_count_next;
  logic                         overflowed;
  logic                         overflowed_next;
  box_t                         run_box;
  box_t                         run_box_next;
  logic                         take;

  assign up_ready = !closed_valid || down_ready;
  assign take     = terms_valid && up_ready;

  always_comb begin
    edge_add  = terms.start ? '0 : CROSS_BITS'(terms.edge_term);
    close_add = terms.last ? CROSS_BITS'(terms.close_term) : '0;
    cross_sum_next = (terms.start ? '0 : cross_sum) + edge_add;
    if (terms.start) begin
      seen_count_next = COUNT_BITS'(1);
      overflowed_next = 1'b0;
      run_box_next    = '{left: terms.x, right: terms.x, bottom: terms.y, top: terms.y};
    end else begin
      seen_count_next = seen_count;
      overflowed_next = overflowed;
      if (seen_count >= COUNT_BITS'(MAX_CORNERS)) begin
        overflowed_next = 1'b1;
      end else begin
        seen_count_next = seen_count + COUNT_BITS'(1);
      end
      run_box_next.left   = (terms.x < run_box.left)   ? terms.x : run_box.left;
      run_box_next.right  = (terms.x > run_box.right)  ? terms.x : run_box.right;
      run_box_next.bottom = (terms.y < run_box.bottom) ? terms.y : run_box.bottom;
      run_box_next.top    = (terms.y > run_box.top)    ? terms.y : run_box.top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_valid <= 1'b0;
    end else if (up_ready) begin
      closed_valid <= terms_valid && terms.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cross_sum  <= cross_sum_next;
      seen_count <= seen_count_next;
      overflowed <= overflowed_next;
      run_box    <= run_box_next;
      if (terms.last) begin
        closed.sum   <= cross_sum_next + close_add;
        closed.count <= seen_count_next;
        closed.ovf   <= overflowed_next;
        closed.box   <= run_box_next;
      end
    end
  end

endmodule

@@ rtl/core/pa_result.sv @@
// Result register: area magnitude, query box overlap and output handshake.
module pa_result (
  input  logic            clk,
  input  logic            rst,
  input  logic            closed_valid,
  input  pa_pkg::closed_t closed,
  input  pa_pkg::query_t  query,
  output logic            up_ready,
  output logic            result_valid,
  output pa_pkg::result_t result,
  input  logic            result_stall
);
  import pa_pkg::*;

  logic [CROSS_BITS-1:0] neg_sum;
  logic [AREA_BITS-1:0]  mag;
  logic                  hit;

  assign up_ready = !result_valid || !result_stall;

  always_comb begin
    neg_sum = -closed.sum;
    if (!closed.sum[CROSS_BITS-1]) begin
      mag = closed.sum[AREA_BITS-1:0];
    end else if (neg_sum[CROSS_BITS-1]) begin
      mag = '1;
    end else begin
      mag = neg_sum[AREA_BITS-1:0];
    end
    hit = (closed.box.right >= query.min_x) && (closed.box.top >= query.min_y) &&
          (closed.box.left <= query.max_x) && (closed.box.bottom <= query.max_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (up_ready) begin
      result_valid <= closed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && closed_valid) begin
      result.twice_area       <= mag;
      result.corner_count     <= closed.count;
      result.box_left         <= closed.box.left;
      result.box_right        <= closed.box.right;
      result.box_bottom       <= closed.box.bottom;
      result.box_top          <= closed.box.top;
      result.overlaps_query   <= hit;
      result.too_many_corners <= closed.ovf;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the polygon area and bounding box block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pa_pkg::*;

  localparam logic signed [COORD_BITS-1:0] COORD_LO = 16'sh8000;
  localparam logic signed [COORD_BITS-1:0] COORD_HI = 16'sh7fff;
  localparam int PHASE_ITEMS = 60;
  localparam int WIND_CORNERS = 1060;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int DIRECTED_ROWS = 21;

  typedef enum {SHAPE_SCATTER, SHAPE_CLUSTER, SHAPE_WIND} shape_t;

  typedef struct {
    vertex_t v;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 vertex_valid;
  vertex_t              vertex;
  logic                 vertex_stall;
  logic                 result_valid;
  result_t              result;
  logic                 result_stall;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  result_t expected_results[$];

  logic signed [COORD_BITS-1:0] qry_min_x = '0;
  logic signed [COORD_BITS-1:0] qry_max_x = '0;
  logic signed [COORD_BITS-1:0] qry_min_y = '0;
  logic signed [COORD_BITS-1:0] qry_max_y = '0;
  longint ring_first_x = 0, ring_first_y = 0, ring_prev_x = 0, ring_prev_y = 0;
  logic [CROSS_BITS-1:0] shoelace_acc = '0;
  int unsigned corners_seen = 0;
  bit corners_overflow = 1'b0;
  longint box_lo_x = 0, box_hi_x = 0, box_lo_y = 0, box_hi_y = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{16'sd0, 16'sd0, 1'b1}, 1'b1,
      '{41'd0, 9'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0}},
    '{'{COORD_LO, COORD_HI, 1'b1}, 1'b1,
      '{41'd0, 9'd1, COORD_LO, COORD_LO, COORD_HI, COORD_HI, 1'b0, 1'b0}},
    '{'{COORD_HI, COORD_LO, 1'b0}, 1'b0, '0},
    '{'{COORD_LO, COORD_HI, 1'b1}, 1'b1,
      '{41'd0, 9'd2, COORD_LO, COORD_HI, COORD_LO, COORD_HI, 1'b1, 1'b0}},
    '{'{COORD_LO, COORD_LO, 1'b0}, 1'b0, '0},
    '{'{COORD_HI, COORD_LO, 1'b0}, 1'b0, '0},
    '{'{COORD_HI, COORD_HI, 1'b1}, 1'b0, '0},
    '{'{COORD_LO, COORD_LO, 1'b0}, 1'b0, '0},
    '{'{COORD_LO, COORD_HI, 1'b0}, 1'b0, '0},
    '{'{COORD_HI, COORD_HI, 1'b0}, 1'b0, '0},
    '{'{COORD_HI, COORD_LO, 1'b1}, 1'b0, '0},
    '{'{-16'sd1, -16'sd1, 1'b0}, 1'b0, '0},
    '{'{16'sd1, -16'sd1, 1'b0}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 1'b0}, 1'b0, '0},
    '{'{-16'sd1, 16'sd1, 1'b1}, 1'b0, '0},
    '{'{16'sd5, 16'sd5, 1'b0}, 1'b0, '0},
    '{'{16'sd5, 16'sd5, 1'b0}, 1'b0, '0},
    '{'{16'sd5, 16'sd5, 1'b1}, 1'b1,
      '{41'd0, 9'd3, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b0, 1'b0}},
    '{'{16'shaaaa, 16'sh5555, 1'b0}, 1'b0, '0},
    '{'{16'sh5555, 16'shaaaa, 1'b0}, 1'b0, '0},
    '{'{16'sh0f0f, 16'shf0f0, 1'b1}, 1'b0, '0}
  };

  polygon_area_and_bbox DUT (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex       (vertex),
    .vertex_stall (vertex_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("MISMATCH result %0d %s: got %0h want %0h", results_seen, field, got, want);
    end
  endtask

  function automatic bit predict_vertex(input vertex_t v, output result_t r);
    longint x, y;
    logic [CROSS_BITS-1:0] mag;
    x = $signed(v.vertex_x);
    y = $signed(v.vertex_y);
    r = '0;
    if (corners_seen == 0) begin
      ring_first_x = x;
      ring_first_y = y;
      shoelace_acc = '0;
      corners_overflow = 1'b0;
      box_lo_x = x;
      box_hi_x = x;
      box_lo_y = y;
      box_hi_y = y;
      corners_seen = 1;
    end else begin
      shoelace_acc = shoelace_acc + CROSS_BITS'(x * ring_prev_y - y * ring_prev_x);
      if (x < box_lo_x) box_lo_x = x;
      if (x > box_hi_x) box_hi_x = x;
      if (y < box_lo_y) box_lo_y = y;
      if (y > box_hi_y) box_hi_y = y;
      if (corners_seen >= MAX_CORNERS) begin
        corners_overflow = 1'b1;
      end else begin
        corners_seen++;
      end
    end
    ring_prev_x = x;
    ring_prev_y = y;
    if (!v.closes_polygon) return 1'b0;
    shoelace_acc = shoelace_acc + CROSS_BITS'(ring_first_x * y - ring_first_y * x);
    mag = shoelace_acc[CROSS_BITS-1] ? CROSS_BITS'(0) - shoelace_acc : shoelace_acc;
    if (mag[CROSS_BITS-1]) mag = {1'b0, {AREA_BITS{1'b1}}};
    r.twice_area = mag[AREA_BITS-1:0];
    r.corner_count = COUNT_BITS'(corners_seen);
    r.box_left = COORD_BITS'(box_lo_x);
    r.box_right = COORD_BITS'(box_hi_x);
    r.box_bottom = COORD_BITS'(box_lo_y);
    r.box_top = COORD_BITS'(box_hi_y);
    r.overlaps_query = box_hi_x >= qry_min_x && box_hi_y >= qry_min_y &&
                       box_lo_x <= qry_max_x && box_lo_y <= qry_max_y;
    r.too_many_corners = corners_overflow;
    corners_seen = 0;
    shoelace_acc = '0;
    corners_overflow = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_vertex(input vertex_t v, input bit typed, input result_t typed_want);
    result_t predicted;
    while (idle_on && $urandom_range(0, 99) < 31) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex <= v;
    do @(negedge clk); while (vertex_stall);
    if (predict_vertex(v, predicted)) begin
      expected_results.insert(expected_results.size(), typed ? typed_want : predicted);
    end
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_BITS-1:0] near_coord(input int centre,
                                                             input int spread);
    int c;
    c = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (c < -32768) c = -32768;
    if (c > 32767) c = 32767;
    return COORD_BITS'(c);
  endfunction

  task automatic send_polygon(input int corners, input shape_t shape);
    vertex_t v;
    int cx, cy, spread;
    cx = $signed(16'($urandom));
    cy = $signed(16'($urandom));
    spread = 1 << $urandom_range(0, 15);
    for (int i = 0; i < corners; i++) begin
      unique case (shape)
        SHAPE_SCATTER: begin
          v.vertex_x = COORD_BITS'($urandom);
          v.vertex_y = COORD_BITS'($urandom);
        end
        SHAPE_CLUSTER: begin
          v.vertex_x = near_coord(cx, spread);
          v.vertex_y = near_coord(cy, spread);
        end
        default: begin
          v.vertex_x = (i % 4 == 1 || i % 4 == 2) ? COORD_HI : COORD_LO;
          v.vertex_y = (i % 4 >= 2) ? COORD_HI : COORD_LO;
        end
      endcase
      v.closes_polygon = (i == corners - 1);
      send_vertex(v, 1'b0, '0);
    end
  endtask

  task automatic write_query(input logic [$clog2(REG_COUNT)-1:0] idx,
                             input logic signed [COORD_BITS-1:0] value);
    logic [DATA_BITS-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    unique case (idx)
      REG_QUERY_MIN_X: qry_min_x = value;
      REG_QUERY_MAX_X: qry_max_x = value;
      REG_QUERY_MIN_Y: qry_min_y = value;
      REG_QUERY_MAX_Y: qry_max_y = value;
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    readback = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[COORD_BITS-1:0] !== value) begin
      report_mismatch("register readback", readback, value);
    end
  endtask

  task automatic set_query_box(input logic signed [COORD_BITS-1:0] min_x, max_x, min_y,
                               max_y);
    write_query(REG_QUERY_MIN_X, min_x);
    write_query(REG_QUERY_MAX_X, max_x);
    write_query(REG_QUERY_MIN_Y, min_y);
    write_query(REG_QUERY_MAX_Y, max_y);
  endtask

  task automatic settle();
    vertex_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= idle_on && ($urandom_range(0, 99) < 31);
      end
    end
  end

  always @(negedge clk) begin
    result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", result.twice_area, '0);
      end else begin
        want = expected_results.pop_front();
        if (result.twice_area !== want.twice_area)
          report_mismatch("twice_area", result.twice_area, want.twice_area);
        if (result.corner_count !== want.corner_count)
          report_mismatch("corner_count", result.corner_count, want.corner_count);
        if (result.box_left !== want.box_left)
          report_mismatch("box_left", result.box_left, want.box_left);
        if (result.box_right !== want.box_right)
          report_mismatch("box_right", result.box_right, want.box_right);
        if (result.box_bottom !== want.box_bottom)
          report_mismatch("box_bottom", result.box_bottom, want.box_bottom);
        if (result.box_top !== want.box_top)
          report_mismatch("box_top", result.box_top, want.box_top);
        if (result.overlaps_query !== want.overlaps_query)
          report_mismatch("overlaps_query", result.overlaps_query, want.overlaps_query);
        if (result.too_many_corners !== want.too_many_corners)
          report_mismatch("too_many_corners", result.too_many_corners,
                          want.too_many_corners);
      end
    end
  end

  initial begin
    int budget, corners, draw;
    logic signed [COORD_BITS-1:0] qa, qb, qc, qd;
    rst = 1'b1;
    vertex_valid = 1'b0;
    vertex = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].want);
    end
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      qa = COORD_BITS'($urandom);
      qb = COORD_BITS'($urandom);
      qc = COORD_BITS'($urandom);
      qd = COORD_BITS'($urandom);
      unique case (phase)
        0: set_query_box(COORD_LO, COORD_HI, COORD_LO, COORD_HI);
        2: set_query_box(COORD_HI, COORD_LO, COORD_HI, COORD_LO);
        4: set_query_box(qa, qb, qc, qd);
        default: set_query_box(qa < qb ? qa : qb, qa < qb ? qb : qa,
                               qc < qd ? qc : qd, qc < qd ? qd : qc);
      endcase
      idle_on = (phase != 0);
      if (phase == 1) hold_request = 1'b1;
      budget = PHASE_ITEMS;
      while (budget > 0) begin
        draw = $urandom_range(0, 99);
        if (phase == 1 && budget > PHASE_ITEMS / 2) begin
          corners = $urandom_range(1, 2);
        end else if (draw < 12) begin
          corners = $urandom_range(1, 2);
        end else if (draw < 80) begin
          corners = $urandom_range(3, 8);
        end else begin
          corners = $urandom_range(9, 40);
        end
        if ($urandom_range(0, 99) < 30) begin
          send_polygon(corners, SHAPE_SCATTER);
        end else begin
          send_polygon(corners, SHAPE_CLUSTER);
        end
        budget -= corners;
      end
      if (phase == 2) send_polygon(MAX_CORNERS, SHAPE_CLUSTER);
      if (phase == 3) send_polygon(WIND_CORNERS, SHAPE_WIND);
    end
    settle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ polygon_area_and_bbox.f @@
rtl/core/pa_pkg.sv
rtl/core/pa_front.sv
rtl/core/pa_cross.sv
rtl/core/pa_accum.sv
rtl/core/pa_result.sv
rtl/core/polygon_area_and_bbox.sv
tb/tb_top.sv
